// File: design/mrp_pkg.sv
// Shared definitions for the MIPS relocation patcher: modifier, field kind
// and error codes, plus the structs passed between the patch stages.
// No dependencies.
`default_nettype none

package mrp_pkg;

   localparam int WordWidth = 32;

   typedef logic [1:0] modifier_type;
   typedef logic [2:0] kind_type;
   typedef logic [2:0] error_type;
   typedef logic [WordWidth-1:0] word_type;

   localparam modifier_type MOD_NONE   = 2'd0;
   localparam modifier_type MOD_LOW    = 2'd1;
   localparam modifier_type MOD_HIGH   = 2'd2;
   localparam modifier_type MOD_BRANCH = 2'd3;

   localparam kind_type KIND_WORD32   = 3'd0;
   localparam kind_type KIND_UNSIGNED16 = 3'd1;
   localparam kind_type KIND_SIGNED16 = 3'd2;
   localparam kind_type KIND_ANY16    = 3'd3;
   localparam kind_type KIND_BRANCH16 = 3'd4;
   localparam kind_type KIND_JUMP26   = 3'd5;

   localparam error_type ERR_OK           = 3'd0;
   localparam error_type ERR_COMBO        = 3'd1;
   localparam error_type ERR_NOT_CLEAR    = 3'd2;
   localparam error_type ERR_FIT16        = 3'd3;
   localparam error_type ERR_BRANCH_RANGE = 3'd4;
   localparam error_type ERR_BRANCH_ALIGN = 3'd5;
   localparam error_type ERR_JUMP_ALIGN   = 3'd6;
   localparam error_type ERR_JUMP_FAR     = 3'd7;

   // One relocation as held in the input register.
   typedef struct packed {
      modifier_type modifier;
      kind_type     field_kind;
      logic         raw;
      word_type     value;
      word_type     patch_offset;
      word_type     original_word;
   } reloc_type;

   // Value after the modifier step and its alignment flag.
   typedef struct packed {
      word_type value;
      logic     align_err;
   } mod_result_type;

   // One patch result as held in the result register.
   typedef struct packed {
      word_type  patched_word;
      logic      is_halfword;
      error_type error_code;
   } patch_type;

endpackage

`default_nettype wire

// File: design/mrp_modifier.sv
// Modifier step of the relocation patcher: low half, adjusted high half or
// signed branch offset. Depends on mrp_pkg.
`default_nettype none

module mrp_modifier
   import mrp_pkg::*;
(
   input  wire modifier_type   modifier,
   input  wire logic           raw,
   input  wire word_type       value,
   output mod_result_type      mod_result
);

   word_type low_sext;
   word_type high_adj;
   word_type neg_value;
   word_type neg_mag;
   word_type branch_off;

   assign low_sext   = {{16{value[15]}}, value[15:0]};
   assign high_adj   = value - low_sext;
   assign neg_value  = 32'd0 - value;
   assign neg_mag    = neg_value >> 2;
   // Signed division by four that truncates toward zero.
   assign branch_off = value[31] ? (32'd0 - neg_mag) : (value >> 2);

   always_comb begin
      mod_result.value     = value;
      mod_result.align_err = 1'b0;
      if (!raw) begin
         unique case (modifier)
            MOD_NONE:   mod_result.value = value;
            MOD_LOW:    mod_result.value = {16'd0, value[15:0]};
            MOD_HIGH:   mod_result.value = {16'd0, high_adj[31:16]};
            MOD_BRANCH: begin
               mod_result.value     = branch_off;
               mod_result.align_err = (value[1:0] != 2'd0);
            end
            default:    mod_result.value = value;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: design/mrp_field_check.sv
// Field stage of the relocation patcher: range, clear and region checks per
// field kind, and the encoding of the patched word. Depends on mrp_pkg.
`default_nettype none

module mrp_field_check
   import mrp_pkg::*;
(
   input  wire modifier_type   modifier,
   input  wire kind_type       field_kind,
   input  wire mod_result_type mod_result,
   input  wire word_type       patch_offset,
   input  wire word_type       original_word,
   output patch_type           patch
);

   word_type v;
   word_type next_pc;
   logic     fits_u16;
   logic     signed16_ok;
   logic     fits_any16;
   logic     orig16_clear;
   logic     half;
   error_type err;
   word_type  word;

   assign v            = mod_result.value;
   assign next_pc      = patch_offset + 32'd4;
   assign fits_u16     = (v[31:16] == 16'd0);
   assign signed16_ok  = (v <= 32'h0000_7fff) || (v >= 32'hffff_8000);
   assign fits_any16   = fits_u16 || (v >= 32'hffff_8000);
   assign orig16_clear = (original_word[15:0] == 16'd0);
   assign half         = (field_kind == KIND_UNSIGNED16) || (field_kind == KIND_SIGNED16) ||
                         (field_kind == KIND_ANY16) || (field_kind == KIND_BRANCH16);

   always_comb begin
      err  = ERR_OK;
      word = '0;
      if (mod_result.align_err) begin
         err = ERR_BRANCH_ALIGN;
      end else begin
         unique case (field_kind)
            KIND_WORD32: begin
               if (modifier != MOD_NONE) err = ERR_COMBO;
               else if (original_word != 32'd0) err = ERR_NOT_CLEAR;
               else word = v;
            end
            KIND_UNSIGNED16: begin
               if (!fits_u16) err = ERR_FIT16;
               else if (!orig16_clear) err = ERR_NOT_CLEAR;
               else word = {16'd0, v[15:0]};
            end
            KIND_SIGNED16: begin
               if (!signed16_ok) err = ERR_FIT16;
               else if (!orig16_clear) err = ERR_NOT_CLEAR;
               else word = {16'd0, v[15:0]};
            end
            KIND_ANY16: begin
               if (!fits_any16) err = ERR_FIT16;
               else if (!orig16_clear) err = ERR_NOT_CLEAR;
               else word = {16'd0, v[15:0]};
            end
            KIND_BRANCH16: begin
               if (!orig16_clear) err = ERR_NOT_CLEAR;
               else if (!signed16_ok) err = ERR_BRANCH_RANGE;
               else word = {16'd0, v[15:0]};
            end
            KIND_JUMP26: begin
               if (modifier != MOD_NONE) err = ERR_COMBO;
               else if (original_word[25:0] != 26'd0) err = ERR_NOT_CLEAR;
               else if (v[1:0] != 2'd0) err = ERR_JUMP_ALIGN;
               else if (v[31:28] != next_pc[31:28]) err = ERR_JUMP_FAR;
               else word = {original_word[31:26], v[27:2]};
            end
            default: err = ERR_COMBO;
         endcase
      end
      // A failed relocation hands back the original contents untouched.
      if (err != ERR_OK) begin
         word = half ? {16'd0, original_word[15:0]} : original_word;
      end
      patch.patched_word = word;
      patch.is_halfword  = half;
      patch.error_code   = err;
   end

endmodule

`default_nettype wire

// File: design/mips_relocation_patcher_unit.sv
// MIPS relocation patcher, top level.
//
// The req_ channel carries one relocation per transfer: the modifier, field
// kind and raw flag in req_tuser, and value, patch offset and the original
// word in req_tdata. The rsp_ channel returns, for each relocation, the
// word to write back in rsp_tdata and the halfword flag and error code in
// rsp_tuser. Results leave in the order the relocations arrived.
//
// Every transfer is registered in an input register, patched by the
// modifier and field logic, and captured in a result register, from which
// it is offered on the rsp_ channel. One relocation is taken every cycle
// while the receiver keeps up.
//
// When the receiver stalls, the result register holds its result and the
// input register keeps the next relocation; req_tready drops only when both
// are full. A synchronous reset empties both registers; no result is
// offered in the cycle after reset.
// Depends on mrp_pkg, mrp_modifier and mrp_field_check.
`default_nettype none

module mips_relocation_patcher_unit
   import mrp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] value, [63:32] patch_offset, [95:64] original_word
   input  wire logic [95:0] req_tdata,
   // [1:0] modifier, [4:2] field_kind, [5] raw
   input  wire logic [5:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] patched_word
   output logic [31:0]      rsp_tdata,
   // [0] is_halfword, [3:1] error_code
   output logic [3:0]       rsp_tuser
);

   logic           in_valid_ff;
   logic           in_valid_in;
   reloc_type      in_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   patch_type      out_ff;
   logic           out_load;
   logic           in_load;
   mod_result_type mod_result;
   patch_type      patch;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_load;
   assign in_load    = req_tvalid && req_tready;

   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_ff.modifier      <= req_tuser[1:0];
         in_ff.field_kind    <= req_tuser[4:2];
         in_ff.raw           <= req_tuser[5];
         in_ff.value         <= req_tdata[31:0];
         in_ff.patch_offset  <= req_tdata[63:32];
         in_ff.original_word <= req_tdata[95:64];
      end
      if (out_load && in_valid_ff) begin
         out_ff <= patch;
      end
   end

   mrp_modifier u_modifier (
      .modifier   (in_ff.modifier),
      .raw        (in_ff.raw),
      .value      (in_ff.value),
      .mod_result (mod_result)
   );

   mrp_field_check u_field_check (
      .modifier      (in_ff.modifier),
      .field_kind    (in_ff.field_kind),
      .mod_result    (mod_result),
      .patch_offset  (in_ff.patch_offset),
      .original_word (in_ff.original_word),
      .patch         (patch)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.patched_word;
   assign rsp_tuser  = {out_ff.error_code, out_ff.is_halfword};

   // A halfword result never carries bits above the halfword.
   a_half_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[31:16] == 16'd0))
      else $error("halfword result has upper bits set");

   // With both registers full and the receiver stalled, no transfer is taken.
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while pipeline full and stalled");

   // Reset leaves no result on offer.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A pending relocation moves to the result register once it is free.
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_load && !in_load) |=> (rsp_tvalid && !in_valid_ff))
      else $error("relocation did not advance to the result register");

endmodule

`default_nettype wire

// File: verif/mips_relocation_patcher_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for mips_relocation_patcher_unit: streams relocations
// with random gaps and stalls and checks each result against its own predictor.
// Depends on mrp_pkg and the patcher RTL.

module mips_relocation_patcher_unit_tb;
   import mrp_pkg::*;

   // Field kinds with no encoding; the block must reject them.
   localparam kind_type KIND_RESERVED6 = 3'd6;
   localparam kind_type KIND_RESERVED7 = 3'd7;
   localparam int RandomRelocs = 1625;
   localparam int IdleLimit = 2000;

   typedef struct {
      reloc_type   reloc;
      int unsigned gap;
      bit          drain;
   } queued_reloc_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [31:0] value, [63:32] patch_offset, [95:64] original_word
   logic [95:0] req_tdata = '0;
   // [1:0] modifier, [4:2] field_kind, [5] raw
   logic [5:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [31:0] patched_word
   logic [31:0] rsp_tdata;
   // [0] is_halfword, [3:1] error_code
   logic [3:0]  rsp_tuser;

   queued_reloc_type relocs_to_send[$];
   patch_type        predicted_patches[$];
   reloc_type        held_reloc;
   bit               send_burst = 1'b0;
   bit               rsp_burst = 1'b0;
   int unsigned      send_wait = 0;
   bit               gap_loaded = 1'b0;
   int unsigned      rsp_stall = 0;
   int unsigned      idle_cycles = 0;
   int unsigned      error_count = 0;
   int unsigned      sent_count = 0;
   int unsigned      checked_count = 0;
   int unsigned      rejected_count = 0;
   logic [7:0]       codes_seen = '0;

   mips_relocation_patcher_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Applies the modifier, then the field checks in priority order.
   function automatic patch_type patch_relocation(reloc_type r);
      patch_type p;
      word_type  v;
      word_type  mag;
      error_type err;
      logic      signed16_ok;
      v = r.value;
      err = ERR_OK;
      p.patched_word = '0;
      p.is_halfword = (r.field_kind >= KIND_UNSIGNED16) && (r.field_kind <= KIND_BRANCH16);
      if (!r.raw) begin
         case (r.modifier)
            MOD_LOW: v = v & 32'h0000_ffff;
            MOD_HIGH: v = (v - {{16{v[15]}}, v[15:0]}) >> 16;
            MOD_BRANCH: begin
               if (v[1:0] != 2'b00) err = ERR_BRANCH_ALIGN;
               // Signed divide by four, truncating toward zero.
               if (v[31]) begin
                  mag = (~v + 32'd1) >> 2;
                  v = ~mag + 32'd1;
               end else begin
                  v = v >> 2;
               end
            end
            default: ;
         endcase
      end
      signed16_ok = (v <= 32'h0000_7fff) || (v >= 32'hffff_8000);
      if (err == ERR_OK) begin
         case (r.field_kind)
            KIND_WORD32: begin
               if (r.modifier != MOD_NONE) err = ERR_COMBO;
               else if (r.original_word != 32'd0) err = ERR_NOT_CLEAR;
               else p.patched_word = v;
            end
            KIND_UNSIGNED16: begin
               if (v > 32'h0000_ffff) err = ERR_FIT16;
               else if (r.original_word[15:0] != 16'd0) err = ERR_NOT_CLEAR;
               else p.patched_word = v & 32'h0000_ffff;
            end
            KIND_SIGNED16: begin
               if (!signed16_ok) err = ERR_FIT16;
               else if (r.original_word[15:0] != 16'd0) err = ERR_NOT_CLEAR;
               else p.patched_word = v & 32'h0000_ffff;
            end
            KIND_ANY16: begin
               if (!(v <= 32'h0000_ffff || v >= 32'hffff_8000)) err = ERR_FIT16;
               else if (r.original_word[15:0] != 16'd0) err = ERR_NOT_CLEAR;
               else p.patched_word = v & 32'h0000_ffff;
            end
            KIND_BRANCH16: begin
               if (r.original_word[15:0] != 16'd0) err = ERR_NOT_CLEAR;
               else if (!signed16_ok) err = ERR_BRANCH_RANGE;
               else p.patched_word = v & 32'h0000_ffff;
            end
            KIND_JUMP26: begin
               if (r.modifier != MOD_NONE) err = ERR_COMBO;
               else if (r.original_word[25:0] != 26'd0) err = ERR_NOT_CLEAR;
               else if (v[1:0] != 2'b00) err = ERR_JUMP_ALIGN;
               else if ((v & 32'hf000_0000) != ((r.patch_offset + 32'd4) & 32'hf000_0000))
                  err = ERR_JUMP_FAR;
               else
                  p.patched_word = (r.original_word & 32'hfc00_0000) |
                                   ((v >> 2) & 32'h03ff_ffff);
            end
            default: err = ERR_COMBO;
         endcase
      end
      if (err != ERR_OK)
         p.patched_word = p.is_halfword ? {16'h0000, r.original_word[15:0]} : r.original_word;
      p.error_code = err;
      return p;
   endfunction

   // Mostly well-formed relocations: sensible modifiers, cleared fields,
   // values near the range edges and jump targets inside their region.
   function automatic reloc_type random_reloc();
      reloc_type   r;
      word_type    base;
      word_type    where4;
      logic [15:0] half16;
      if ($urandom_range(0, 49) == 0)
         r.field_kind = kind_type'($urandom_range(KIND_RESERVED6, KIND_RESERVED7));
      else
         r.field_kind = kind_type'($urandom_range(KIND_WORD32, KIND_JUMP26));
      r.modifier = modifier_type'($urandom_range(MOD_NONE, MOD_BRANCH));
      r.raw = ($urandom_range(0, 4) == 0);
      if ((r.field_kind == KIND_WORD32 || r.field_kind == KIND_JUMP26) &&
          $urandom_range(0, 4) != 0)
         r.modifier = MOD_NONE;
      else if (r.field_kind == KIND_BRANCH16 && $urandom_range(0, 2) != 0)
         r.modifier = MOD_BRANCH;
      r.patch_offset = $urandom;
      where4 = r.patch_offset + 32'd4;
      half16 = 16'($urandom);
      case ($urandom_range(0, 3))
         0: r.value = $urandom;
         1: r.value = {{16{half16[15]}}, half16};
         default: begin
            case ($urandom_range(0, 5))
               0: base = 32'h0000_7fff;
               1: base = 32'h0000_8000;
               2: base = 32'h0000_ffff;
               3: base = 32'h0001_0000;
               4: base = 32'hffff_8000;
               default: base = 32'h0000_0000;
            endcase
            r.value = base + $urandom_range(0, 6) - 32'd3;
         end
      endcase
      if (r.modifier == MOD_BRANCH && !r.raw) begin
         r.value = r.value << 2;
         if ($urandom_range(0, 7) == 0) r.value[1:0] = 2'($urandom_range(1, 3));
      end
      if (r.field_kind == KIND_JUMP26 && $urandom_range(0, 3) != 0) begin
         r.value = (where4 & 32'hf000_0000) | ($urandom & 32'h0fff_fffc);
         if ($urandom_range(0, 9) == 0) r.value[1:0] = 2'($urandom_range(1, 3));
         if ($urandom_range(0, 9) == 0) r.value[31:28] = 4'($urandom);
      end
      r.original_word = $urandom;
      if ($urandom_range(0, 3) != 0) begin
         case (r.field_kind)
            KIND_WORD32: r.original_word = '0;
            KIND_JUMP26: r.original_word[25:0] = '0;
            KIND_RESERVED6, KIND_RESERVED7: ;
            default: r.original_word[15:0] = '0;
         endcase
      end
      return r;
   endfunction

   task automatic queue_reloc(input reloc_type r, input bit drain);
      queued_reloc_type q;
      if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
      q.reloc = r;
      q.gap = send_burst ? 0 : $urandom_range(0, 10);
      q.drain = drain;
      relocs_to_send.push_back(q);
   endtask

   task automatic queue_fields(input modifier_type m, input kind_type k, input logic raw,
                               input word_type v, input word_type off, input word_type orig);
      reloc_type r;
      r.modifier = m;
      r.field_kind = k;
      r.raw = raw;
      r.value = v;
      r.patch_offset = off;
      r.original_word = orig;
      queue_reloc(r, 1'b0);
   endtask

   // Sender: each relocation waits out its gap, and a drain-marked one also
   // waits until every outstanding result has been returned.
   always @(posedge clock) begin : send_relocs
      logic      fire;
      logic      next_valid;
      patch_type predicted;
      fire = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (fire) begin
            predicted = patch_relocation(held_reloc);
            predicted_patches.push_back(predicted);
            sent_count++;
            codes_seen[predicted.error_code] = 1'b1;
            if (predicted.error_code != ERR_OK) rejected_count++;
         end
         if (!req_tvalid || fire) begin
            next_valid = 1'b0;
            if (relocs_to_send.size() != 0) begin
               if (!gap_loaded) begin
                  send_wait = relocs_to_send[0].gap;
                  gap_loaded = 1'b1;
               end
               if (send_wait > 0) begin
                  send_wait--;
               end else if (!relocs_to_send[0].drain || predicted_patches.size() == 0) begin
                  held_reloc = relocs_to_send.pop_front().reloc;
                  gap_loaded = 1'b0;
                  next_valid = 1'b1;
                  req_tdata <= {held_reloc.original_word, held_reloc.patch_offset,
                                held_reloc.value};
                  req_tuser <= {held_reloc.raw, held_reloc.field_kind, held_reloc.modifier};
               end
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // Receiver: checks each result transfer, then draws its next stall.
   always @(posedge clock) begin : check_patches
      patch_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_patches.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got word %h flags %h",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = predicted_patches.pop_front();
               checked_count++;
               if (rsp_tdata !== want.patched_word) begin
                  error_count++;
                  $display("%0t: patched_word expected %h, got %h",
                           $time, want.patched_word, rsp_tdata);
               end
               if (rsp_tuser[0] !== want.is_halfword) begin
                  error_count++;
                  $display("%0t: is_halfword expected %b, got %b",
                           $time, want.is_halfword, rsp_tuser[0]);
               end
               if (rsp_tuser[3:1] !== want.error_code) begin
                  error_count++;
                  $display("%0t: error_code expected %0d, got %0d",
                           $time, want.error_code, rsp_tuser[3:1]);
               end
            end
            if ($urandom_range(0, 99) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 10);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_stall == 0);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: no transfer on either channel for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned n;
      // Word fields: clean, not clear, and a modifier where none is allowed.
      queue_fields(MOD_NONE, KIND_WORD32, 1'b0, 32'hffff_ffff, 32'h0, 32'h0);
      queue_fields(MOD_NONE, KIND_WORD32, 1'b0, 32'h0, 32'hffff_ffff, 32'hffff_ffff);
      queue_fields(MOD_LOW, KIND_WORD32, 1'b0, 32'h1234_5678, 32'h0, 32'h0);
      // A raw record still may not carry a modifier on a word field.
      queue_fields(MOD_HIGH, KIND_WORD32, 1'b1, 32'h1234_5678, 32'h0, 32'h0);
      // Halfword range edges, including the widened any16 range.
      queue_fields(MOD_LOW, KIND_UNSIGNED16, 1'b0, 32'hffff_ffff, 32'h0, 32'hffff_0000);
      queue_fields(MOD_NONE, KIND_UNSIGNED16, 1'b0, 32'h0001_0000, 32'h0, 32'h0);
      queue_fields(MOD_NONE, KIND_UNSIGNED16, 1'b0, 32'h0000_ffff, 32'h0, 32'h0000_0001);
      queue_fields(MOD_NONE, KIND_SIGNED16, 1'b0, 32'h0000_7fff, 32'h0, 32'h0);
      queue_fields(MOD_NONE, KIND_SIGNED16, 1'b0, 32'hffff_8000, 32'h0, 32'h0);
      queue_fields(MOD_NONE, KIND_SIGNED16, 1'b0, 32'h0000_8000, 32'h0, 32'h0);
      queue_fields(MOD_NONE, KIND_SIGNED16, 1'b0, 32'hffff_7fff, 32'h0, 32'h0);
      queue_fields(MOD_NONE, KIND_ANY16, 1'b0, 32'h0000_ffff, 32'h0, 32'h0);
      queue_fields(MOD_NONE, KIND_ANY16, 1'b0, 32'hffff_8000, 32'h0, 32'h0);
      queue_fields(MOD_NONE, KIND_ANY16, 1'b0, 32'hffff_7fff, 32'h0, 32'h0);
      // High half carries into the upper part when the low half is negative.
      queue_fields(MOD_HIGH, KIND_ANY16, 1'b0, 32'h1234_8000, 32'h0, 32'h0);
      queue_fields(MOD_HIGH, KIND_SIGNED16, 1'b0, 32'h7fff_8000, 32'h0, 32'h0);
      // Branch offsets: negative, misaligned, range edges, misaligned with the field not clear, raw.
      queue_fields(MOD_BRANCH, KIND_BRANCH16, 1'b0, 32'hffff_fffc, 32'h0, 32'h0);
      queue_fields(MOD_BRANCH, KIND_BRANCH16, 1'b0, 32'hffff_fffe, 32'h0, 32'h0);
      queue_fields(MOD_BRANCH, KIND_BRANCH16, 1'b0, 32'h0001_fffc, 32'h0, 32'h0);
      queue_fields(MOD_BRANCH, KIND_BRANCH16, 1'b0, 32'h0002_0000, 32'h0, 32'h0);
      queue_fields(MOD_BRANCH, KIND_BRANCH16, 1'b0, 32'h0000_0006, 32'h0, 32'h0000_0001);
      queue_fields(MOD_BRANCH, KIND_BRANCH16, 1'b1, 32'h0000_0003, 32'h0, 32'h0);
      // Jumps: in region, across a region edge, wrapped, misaligned.
      queue_fields(MOD_NONE, KIND_JUMP26, 1'b0, 32'h0fff_fffc, 32'h0fff_fff8, 32'hfc00_0000);
      queue_fields(MOD_NONE, KIND_JUMP26, 1'b0, 32'h0000_0100, 32'h0fff_fffc, 32'h0);
      queue_fields(MOD_NONE, KIND_JUMP26, 1'b0, 32'h0000_0004, 32'hffff_fffc, 32'h0);
      queue_fields(MOD_NONE, KIND_JUMP26, 1'b0, 32'h0000_0102, 32'h0, 32'h0);
      queue_fields(MOD_LOW, KIND_JUMP26, 1'b0, 32'h0000_0100, 32'h0, 32'h0);
      queue_fields(MOD_NONE, KIND_JUMP26, 1'b0, 32'h0000_0100, 32'h0, 32'h0000_0001);
      queue_fields(MOD_NONE, KIND_RESERVED6, 1'b0, 32'h0, 32'h0, 32'hdead_beef);
      queue_fields(MOD_BRANCH, KIND_RESERVED7, 1'b1, 32'h0, 32'h0, 32'h1234_5678);
      // Every 400th random record holds off until the pipeline has drained.
      for (n = 0; n < RandomRelocs; n++)
         queue_reloc(random_reloc(), (n % 400) == 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (relocs_to_send.size() != 0 || req_tvalid) @(posedge clock);
      while (predicted_patches.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d relocations and checked %0d results, %0d of them rejected.",
               sent_count, checked_count, rejected_count);
      $display("Error codes seen (bit per code, 7 down to 0): %b", codes_seen);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: mips_relocation_patcher_unit.f
design/mrp_pkg.sv
design/mrp_modifier.sv
design/mrp_field_check.sv
design/mips_relocation_patcher_unit.sv
verif/mips_relocation_patcher_unit_tb.sv
